FILE: rtl/mfs_pkg.sv
`default_nettype none

package mfs_pkg;

  // Register indexes on the configuration channel
  localparam logic [2:0] REG_SPIN_SPEED_LIMIT     = 3'd0;
  localparam logic [2:0] REG_SPIN_TICK_LIMIT      = 3'd1;
  localparam logic [2:0] REG_LEVEL_WINDOW         = 3'd2;
  localparam logic [2:0] REG_STILL_DELTA          = 3'd3;
  localparam logic [2:0] REG_SAMPLE_INTERVAL      = 3'd4;
  localparam logic [2:0] REG_STILL_SAMPLES_NEEDED = 3'd5;
  localparam logic [2:0] REG_TILT_LIMIT           = 3'd6;

  // Reset values of the registers (angles in 0.01 degree)
  localparam logic [14:0] RST_SPIN_SPEED_LIMIT     = 15'd300;
  localparam logic [9:0]  RST_SPIN_TICK_LIMIT      = 10'd50;
  localparam logic [14:0] RST_LEVEL_WINDOW         = 15'd500;
  localparam logic [15:0] RST_STILL_DELTA          = 16'd80;
  localparam logic [9:0]  RST_SAMPLE_INTERVAL      = 10'd50;
  localparam logic [3:0]  RST_STILL_SAMPLES_NEEDED = 4'd4;
  localparam logic [14:0] RST_TILT_LIMIT           = 15'd3000;

  // Counter saturation points
  localparam logic [10:0] SPIN_RUN_MAX    = 11'd2047;
  localparam logic [9:0]  LEVEL_TICKS_MAX = 10'd1023;
  localparam logic [3:0]  STILL_RUN_MAX   = 4'd15;

  typedef struct packed {
    logic [14:0] spin_speed_limit;
    logic [9:0]  spin_tick_limit;
    logic [14:0] level_window;
    logic [15:0] still_delta;
    logic [9:0]  sample_interval;
    logic [3:0]  still_samples_needed;
    logic [14:0] tilt_limit;
  } cfg_t;

  typedef struct packed {
    logic [10:0] spin_run;
    logic        spin_latched;
    logic [9:0]  level_ticks;
    logic [3:0]  still_run;
    logic [15:0] last_sample_angle;
  } state_t;

  typedef struct packed {
    logic [15:0] left_count;
    logic [15:0] right_count;
    logic [15:0] tilt_angle;
    logic        target_zero;
  } item_t;

  typedef struct packed {
    logic spin_fault;
    logic tilt_fault;
    logic position_clear;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/mfs_if.sv
`default_nettype none

// Tick input channel
interface mfs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;
  logic signed [15:0] tilt_angle;
  logic               target_zero;

  modport source (output valid, left_count, right_count, tilt_angle, target_zero,
                  input ready);
  modport sink (input valid, left_count, right_count, tilt_angle, target_zero,
                output ready);
endinterface

// Fault result channel
interface mfs_out_if;
  logic valid;
  logic ready;
  logic spin_fault;
  logic tilt_fault;
  logic position_clear;

  modport source (output valid, spin_fault, tilt_fault, position_clear, input ready);
  modport sink (input valid, spin_fault, tilt_fault, position_clear, output ready);
endinterface

// Register write channel
interface mfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mfs_cfg_regs.sv
`default_nettype none

module mfs_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst,
  mfs_cfg_if.sink      cfg,
  output mfs_pkg::cfg_t regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Register file, data masked to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.spin_speed_limit     <= mfs_pkg::RST_SPIN_SPEED_LIMIT;
      regs.spin_tick_limit      <= mfs_pkg::RST_SPIN_TICK_LIMIT;
      regs.level_window         <= mfs_pkg::RST_LEVEL_WINDOW;
      regs.still_delta          <= mfs_pkg::RST_STILL_DELTA;
      regs.sample_interval      <= mfs_pkg::RST_SAMPLE_INTERVAL;
      regs.still_samples_needed <= mfs_pkg::RST_STILL_SAMPLES_NEEDED;
      regs.tilt_limit           <= mfs_pkg::RST_TILT_LIMIT;
    end else if (cfg.valid) begin
      case (cfg.index)
        mfs_pkg::REG_SPIN_SPEED_LIMIT:     regs.spin_speed_limit     <= cfg.data[14:0];
        mfs_pkg::REG_SPIN_TICK_LIMIT:      regs.spin_tick_limit      <= cfg.data[9:0];
        mfs_pkg::REG_LEVEL_WINDOW:         regs.level_window         <= cfg.data[14:0];
        mfs_pkg::REG_STILL_DELTA:          regs.still_delta          <= cfg.data;
        mfs_pkg::REG_SAMPLE_INTERVAL:      regs.sample_interval      <= cfg.data[9:0];
        mfs_pkg::REG_STILL_SAMPLES_NEEDED: regs.still_samples_needed <= cfg.data[3:0];
        mfs_pkg::REG_TILT_LIMIT:           regs.tilt_limit           <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mfs_step.sv
`default_nettype none

module mfs_step (
  input  wire mfs_pkg::cfg_t    regs,
  input  wire mfs_pkg::state_t  cur,
  input  wire mfs_pkg::item_t   item,
  output mfs_pkg::state_t       nxt,
  output mfs_pkg::result_t      res
);

  // Sign-extended operands and bounds, 17 bit signed; still-delta terms 18 bit signed
  logic signed [16:0] left_ext, right_ext, angle_ext, last_ext;
  logic signed [16:0] spd_pos, spd_neg, win_pos, win_neg, tilt_pos, tilt_neg;
  logic signed [16:0] diff;
  logic signed [17:0] diff_ext, dl_pos, dl_neg;
  logic               spin_hit, in_window, still;
  logic [10:0]        run_inc;
  logic [9:0]         level_inc;
  logic [3:0]         still_inc;
  logic               latched_mid;

  assign left_ext  = $signed({item.left_count[15], item.left_count});
  assign right_ext = $signed({item.right_count[15], item.right_count});
  assign angle_ext = $signed({item.tilt_angle[15], item.tilt_angle});
  assign last_ext  = $signed({cur.last_sample_angle[15], cur.last_sample_angle});

  assign spd_pos  = $signed({2'b00, regs.spin_speed_limit});
  assign spd_neg  = -spd_pos;
  assign win_pos  = $signed({2'b00, regs.level_window});
  assign win_neg  = -win_pos;
  assign tilt_pos = $signed({2'b00, regs.tilt_limit});
  assign tilt_neg = -tilt_pos;

  assign diff     = angle_ext - last_ext;
  assign diff_ext = $signed({diff[16], diff});
  assign dl_pos   = $signed({2'b00, regs.still_delta});
  assign dl_neg   = -dl_pos;

  // Both wheels beyond the limit in the same direction, target zero
  assign spin_hit = item.target_zero &&
                    ((left_ext > spd_pos && right_ext > spd_pos) ||
                     (left_ext < spd_neg && right_ext < spd_neg));
  assign in_window = (angle_ext > win_neg) && (angle_ext < win_pos);
  assign still     = (diff_ext < dl_pos) && (diff_ext > dl_neg);

  // Saturating increments
  assign run_inc   = (cur.spin_run != mfs_pkg::SPIN_RUN_MAX) ?
                     cur.spin_run + 11'd1 : cur.spin_run;
  assign level_inc = (cur.level_ticks != mfs_pkg::LEVEL_TICKS_MAX) ?
                     cur.level_ticks + 10'd1 : cur.level_ticks;
  assign still_inc = (cur.still_run != mfs_pkg::STILL_RUN_MAX) ?
                     cur.still_run + 4'd1 : cur.still_run;

  // Spin check, then landing check on the updated latch
  always_comb begin
    nxt = cur;
    res.position_clear = 1'b0;
    latched_mid = cur.spin_latched;

    if (spin_hit) begin
      if (run_inc > {1'b0, regs.spin_tick_limit}) begin
        nxt.spin_run = '0;
        latched_mid  = 1'b1;
      end else begin
        nxt.spin_run = run_inc;
      end
    end else begin
      nxt.spin_run = '0;
    end
    nxt.spin_latched = latched_mid;

    if (latched_mid) begin
      if (in_window) begin
        nxt.level_ticks = level_inc;
        if (level_inc >= regs.sample_interval) begin
          nxt.level_ticks = '0;
          if (still) begin
            nxt.still_run = still_inc;
            if (still_inc >= regs.still_samples_needed) begin
              nxt.still_run      = '0;
              nxt.spin_latched   = 1'b0;
              res.position_clear = 1'b1;
            end
          end else begin
            nxt.still_run = '0;
          end
          nxt.last_sample_angle = item.tilt_angle;
        end
      end else begin
        nxt.level_ticks = '0;
        nxt.still_run   = '0;
      end
    end

    res.spin_fault = nxt.spin_latched;
    res.tilt_fault = (angle_ext > tilt_pos) || (angle_ext < tilt_neg);
  end

endmodule

`default_nettype wire

FILE: rtl/motor_fault_supervisor.sv
// Motor fault supervisor: spin latch, landing release and tilt check per tick.
// Each accepted input beat passes the input register, then the result register.
// Throughput: one tick per cycle; input register and result register each stall
// only when the stage after them is full and not taken.
// Reset (rst, synchronous): registers return to defaults, counters, latch and
// last sample angle clear, both pipeline stages empty.
`default_nettype none

module motor_fault_supervisor (
  input  wire logic  clk,
  input  wire logic  rst,
  mfs_in_if.sink     samples,
  mfs_out_if.source  results,
  mfs_cfg_if.sink    cfg
);

  mfs_pkg::cfg_t    regs;
  mfs_pkg::state_t  st, st_next;
  mfs_pkg::item_t   item;
  mfs_pkg::result_t res, res_next;
  logic             item_valid, res_valid;
  logic             res_load, item_load;

  mfs_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mfs_step u_step (
    .regs (regs),
    .cur  (st),
    .item (item),
    .nxt  (st_next),
    .res  (res_next)
  );

  // Stage handshakes
  assign res_load      = item_valid && (!res_valid || results.ready);
  assign item_load     = samples.valid && samples.ready;
  assign samples.ready = !item_valid || res_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (samples.ready) begin
      item_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item.left_count  <= samples.left_count;
      item.right_count <= samples.right_count;
      item.tilt_angle  <= samples.tilt_angle;
      item.target_zero <= samples.target_zero;
    end
  end

  // Supervisor state, advanced once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (res_load) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  assign results.valid          = res_valid;
  assign results.spin_fault     = res.spin_fault;
  assign results.tilt_fault     = res.tilt_fault;
  assign results.position_clear = res.position_clear;

endmodule

`default_nettype wire

FILE: verif/mfs_fault_check.sv
// Watches the tick, result and register channels, predicts the fault flags of
// every accepted tick and compares them with the result beats in order.
module mfs_fault_check (
  input  wire logic clk,
  input  wire logic rst,
  mfs_in_if         samples,
  mfs_out_if        results,
  mfs_cfg_if        cfg,
  output int        mismatches,
  output int        outstanding
);
  import mfs_pkg::*;

  cfg_t    regs;
  state_t  st;
  result_t expected_flags[$];

  // Register write, masked to the width of the target; unknown index ignored
  function automatic void store_reg(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      REG_SPIN_SPEED_LIMIT:     regs.spin_speed_limit     = data[14:0];
      REG_SPIN_TICK_LIMIT:      regs.spin_tick_limit      = data[9:0];
      REG_LEVEL_WINDOW:         regs.level_window         = data[14:0];
      REG_STILL_DELTA:          regs.still_delta          = data;
      REG_SAMPLE_INTERVAL:      regs.sample_interval      = data[9:0];
      REG_STILL_SAMPLES_NEEDED: regs.still_samples_needed = data[3:0];
      REG_TILT_LIMIT:           regs.tilt_limit           = data[14:0];
      default: ;
    endcase
  endfunction

  // One control tick: spin latch, then landing release, then tilt check
  function automatic result_t supervise_tick(input logic signed [15:0] left,
                                             input logic signed [15:0] right,
                                             input logic signed [15:0] angle,
                                             input logic tzero);
    int      spd, window, dlim, tlim, diff;
    result_t res;
    spd    = int'(regs.spin_speed_limit);
    window = int'(regs.level_window);
    dlim   = int'(regs.still_delta);
    tlim   = int'(regs.tilt_limit);
    res.position_clear = 1'b0;

    // both wheels running away the same way while parked
    if (tzero && ((left > spd && right > spd) || (left < -spd && right < -spd))) begin
      if (st.spin_run < SPIN_RUN_MAX) st.spin_run = st.spin_run + 1'b1;
      if (st.spin_run > regs.spin_tick_limit) begin
        st.spin_run     = '0;
        st.spin_latched = 1'b1;
      end
    end else begin
      st.spin_run = '0;
    end

    // landing: sample the angle at the set interval while level
    if (st.spin_latched) begin
      if (angle > -window && angle < window) begin
        if (st.level_ticks < LEVEL_TICKS_MAX) st.level_ticks = st.level_ticks + 1'b1;
        if (st.level_ticks >= regs.sample_interval) begin
          diff = int'(angle) - int'($signed(st.last_sample_angle));
          st.level_ticks = '0;
          if (diff < dlim && diff > -dlim) begin
            if (st.still_run < STILL_RUN_MAX) st.still_run = st.still_run + 1'b1;
            if (st.still_run >= regs.still_samples_needed) begin
              st.still_run       = '0;
              st.level_ticks     = '0;
              st.spin_latched    = 1'b0;
              res.position_clear = 1'b1;
            end
          end else begin
            st.still_run = '0;
          end
          st.last_sample_angle = angle;
        end
      end else begin
        st.level_ticks = '0;
        st.still_run   = '0;
      end
    end

    res.tilt_fault = (angle > tlim || angle < -tlim);
    res.spin_fault = st.spin_latched;
    return res;
  endfunction

  // Result beats are checked before this edge's tick beat is predicted
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs = '{RST_SPIN_SPEED_LIMIT, RST_SPIN_TICK_LIMIT, RST_LEVEL_WINDOW,
               RST_STILL_DELTA, RST_SAMPLE_INTERVAL, RST_STILL_SAMPLES_NEEDED,
               RST_TILT_LIMIT};
      st = '0;
      expected_flags.delete();
      mismatches = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_flags.size() == 0) begin
          $error("result beat with no tick outstanding");
          mismatches++;
        end else begin
          want = expected_flags.pop_front();
          if (results.spin_fault !== want.spin_fault) begin
            $error("spin_fault: expected %0b, got %0b", want.spin_fault, results.spin_fault);
            mismatches++;
          end
          if (results.tilt_fault !== want.tilt_fault) begin
            $error("tilt_fault: expected %0b, got %0b", want.tilt_fault, results.tilt_fault);
            mismatches++;
          end
          if (results.position_clear !== want.position_clear) begin
            $error("position_clear: expected %0b, got %0b",
                   want.position_clear, results.position_clear);
            mismatches++;
          end
        end
      end
      if (cfg.valid && cfg.ready) store_reg(cfg.index, cfg.data);
      if (samples.valid && samples.ready)
        expected_flags.push_back(supervise_tick(samples.left_count, samples.right_count,
                                                samples.tilt_angle, samples.target_zero));
    end
    outstanding = expected_flags.size();
  end

endmodule

FILE: verif/tb.sv
module tb;
  import mfs_pkg::*;

  // index past the register file; writes to it must be dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]  idx;
    logic [15:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches, outstanding;

  mfs_in_if  samples();
  mfs_out_if results();
  mfs_cfg_if cfg();

  motor_fault_supervisor dut (.clk, .rst, .samples, .results, .cfg);

  mfs_fault_check fault_check (
    .clk, .rst, .samples, .results, .cfg, .mismatches, .outstanding
  );

  always #4 clk = ~clk;

  bit         idle_on;
  int         items_sent;
  int         sink_hold;
  reg_write_t pending_writes[$];
  // settings of the current random phase, used to shape ticks
  int spd_now, ticklim_now, window_now, delta_now, interval_now, needed_now;

  // Result side: ready drops in bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      sink_hold = 0;
      results.ready <= 1'b0;
    end else begin
      if (sink_hold > 0) sink_hold = sink_hold - 1;
      else if (idle_on && $urandom_range(9, 0) == 0) sink_hold = $urandom_range(17, 1);
      results.ready <= (sink_hold == 0);
    end
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Holds valid until the beat is taken; may leave a gap afterwards
  task automatic drive_tick(input logic signed [15:0] l, input logic signed [15:0] r,
                            input logic signed [15:0] a, input logic tz);
    samples.left_count  <= l;
    samples.right_count <= r;
    samples.tilt_angle  <= a;
    samples.target_zero <= tz;
    samples.valid       <= 1'b1;
    do @(posedge clk); while (!samples.ready);
    items_sent++;
    if (idle_on && $urandom_range(9, 0) == 0) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every tick has its result back
  task automatic drain_results();
    samples.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Queue a write; bits above the register width sometimes carry junk
  task automatic stage_reg(input logic [2:0] idx, input int value, input int width);
    logic [15:0] d;
    d = 16'(value);
    if (width < 16 && $urandom_range(3, 0) == 0) d = d | (16'($urandom()) << width);
    pending_writes.push_back('{idx, d});
  endtask

  // Registers change only once the block has gone quiet
  task automatic apply_writes();
    drain_results();
    foreach (pending_writes[i]) begin
      cfg.index <= pending_writes[i].idx;
      cfg.data  <= pending_writes[i].data;
      cfg.valid <= 1'b1;
      do @(posedge clk); while (!cfg.ready);
    end
    cfg.valid <= 1'b0;
    pending_writes.delete();
  endtask

  // Wheel count beyond the spin limit; positive side impossible at the top limit
  function automatic logic signed [15:0] fast_count(input int spd, input bit neg);
    int lo, hi, mag;
    bit n;
    lo = spd + 1;
    n  = neg || lo > 32767;
    hi = n ? 32768 : 32767;
    if ($urandom_range(1, 0) && lo + 40 < hi) hi = lo + 40;
    mag = $urandom_range(hi, lo);
    return 16'(n ? -mag : mag);
  endfunction

  function automatic logic signed [15:0] slow_count(input int spd);
    return 16'(int'($urandom_range(2 * spd, 0)) - spd);
  endfunction

  function automatic int in_window_angle();
    if (window_now == 0) return 0;
    return int'($urandom_range(2 * (window_now - 1), 0)) - (window_now - 1);
  endfunction

  function automatic int outside_angle();
    int a;
    a = $urandom_range(18000, window_now);
    return $urandom_range(1, 0) ? -a : a;
  endfunction

  task automatic noise_tick();
    drive_tick(16'($urandom()), 16'($urandom()),
               16'(int'($urandom_range(36000, 0)) - 18000), 1'($urandom()));
  endtask

  // Run of spinning ticks long enough to latch, now and then broken
  task automatic spin_episode();
    int n;
    bit neg;
    n   = ticklim_now + 1 + $urandom_range(2, 0);
    neg = $urandom_range(1, 0);
    repeat (n) begin
      if ($urandom_range(29, 0) == 0)
        drive_tick(fast_count(spd_now, neg), slow_count(spd_now),
                   16'(in_window_angle()), 1'b1);
      else
        drive_tick(fast_count(spd_now, neg), fast_count(spd_now, neg),
                   16'(in_window_angle()), $urandom_range(39, 0) != 0);
    end
  endtask

  // Mostly level and still, with drops out of the window, jumps and spins
  task automatic landing_episode();
    int n, base, a, j, pick;
    base = in_window_angle();
    j    = delta_now / 2;
    if (j > 2000) j = 2000;
    n = (interval_now == 0 ? 1 : interval_now) * (needed_now + 1) + $urandom_range(5, 0);
    repeat (n) begin
      pick = $urandom_range(99, 0);
      if (pick < 85) begin
        a = base + int'($urandom_range(2 * j, 0)) - j;
        if (a > window_now - 1) a = window_now - 1;
        if (a < 1 - window_now) a = 1 - window_now;
        if (window_now == 0) a = 0;
      end else if (pick < 92) begin
        a = outside_angle();
      end else begin
        a = in_window_angle();
      end
      if (pick >= 97)
        drive_tick(fast_count(spd_now, 1'b1), fast_count(spd_now, 1'b1), 16'(a), 1'b1);
      else
        drive_tick(slow_count(spd_now), slow_count(spd_now), 16'(a), 1'($urandom()));
    end
  endtask

  // New settings for a random phase, extremes now and then
  task automatic random_settings();
    int pick, tilt;
    pick = $urandom_range(19, 0);
    spd_now = pick == 0 ? 0 : pick == 1 ? 32767 : $urandom_range(600, 0);
    ticklim_now = $urandom_range(9, 0) == 0 ? 0 : $urandom_range(8, 1);
    pick = $urandom_range(19, 0);
    window_now = pick == 0 ? 0 : pick == 1 ? 18000 : $urandom_range(3000, 100);
    pick = $urandom_range(19, 0);
    delta_now = pick == 0 ? 0 : pick == 1 ? 36000 : $urandom_range(400, 10);
    interval_now = $urandom_range(29, 0) == 0 ? 0 : $urandom_range(6, 1);
    needed_now = $urandom_range(19, 0) == 0 ? 15 : $urandom_range(4, 1);
    pick = $urandom_range(19, 0);
    tilt = pick == 0 ? 0 : pick == 1 ? 32767 : $urandom_range(18000, 0);
    stage_reg(REG_SPIN_SPEED_LIMIT, spd_now, 15);
    stage_reg(REG_SPIN_TICK_LIMIT, ticklim_now, 10);
    stage_reg(REG_LEVEL_WINDOW, window_now, 15);
    stage_reg(REG_STILL_DELTA, delta_now, 16);
    stage_reg(REG_SAMPLE_INTERVAL, interval_now, 10);
    stage_reg(REG_STILL_SAMPLES_NEEDED, needed_now, 4);
    stage_reg(REG_TILT_LIMIT, tilt, 15);
    if ($urandom_range(3, 0) == 0) stage_reg(REG_UNUSED, $urandom(), 0);
    apply_writes();
  endtask

  initial begin
    int  target, phase_end, pick, phase;
    bit  neg, phase_idle;
    samples.valid       <= 1'b0;
    samples.left_count  <= '0;
    samples.right_count <= '0;
    samples.tilt_angle  <= '0;
    samples.target_zero <= 1'b0;
    cfg.valid           <= 1'b0;
    cfg.index           <= '0;
    cfg.data            <= '0;
    idle_on    = 1'b1;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Field extremes and tilt bounds under the reset settings
    drive_tick(16'sd32767, 16'sd32767, 16'sd18000, 1'b1);
    drive_tick(-16'sd32768, -16'sd32768, -16'sd18000, 1'b1);
    drive_tick(16'sd301, 16'sd301, 16'sd3000, 1'b1);
    drive_tick(16'sd300, 16'sd301, 16'sd3001, 1'b1);
    drive_tick(-16'sd301, -16'sd301, -16'sd3000, 1'b0);
    drive_tick(-16'sd300, -16'sd301, -16'sd3001, 1'b1);
    drive_tick(16'sd32767, -16'sd32768, 16'sd0, 1'b1);
    drive_tick(16'sd0, 16'sd0, 16'sd0, 1'b0);
    drive_tick(16'sh5555, 16'shAAAA, 16'sd1, 1'b0);

    // Zero limits: latch and landing on one tick, zero interval and count
    stage_reg(REG_SPIN_SPEED_LIMIT, 0, 15);
    stage_reg(REG_SPIN_TICK_LIMIT, 0, 10);
    stage_reg(REG_SAMPLE_INTERVAL, 0, 10);
    stage_reg(REG_STILL_SAMPLES_NEEDED, 0, 4);
    stage_reg(REG_TILT_LIMIT, 0, 15);
    apply_writes();
    drive_tick(16'sd0, 16'sd0, 16'sd0, 1'b1);
    drive_tick(16'sd1, 16'sd1, 16'sd0, 1'b1);
    drive_tick(-16'sd1, -16'sd1, 16'sd1, 1'b1);
    drive_tick(-16'sd1, 16'sd1, -16'sd1, 1'b1);

    // Closed window and zero delta hold the latch; spin again while latched
    stage_reg(REG_SPIN_TICK_LIMIT, 1, 10);
    stage_reg(REG_LEVEL_WINDOW, 0, 15);
    stage_reg(REG_STILL_DELTA, 0, 16);
    stage_reg(REG_SAMPLE_INTERVAL, 5, 10);
    stage_reg(REG_TILT_LIMIT, 18000, 15);
    stage_reg(REG_UNUSED, 16'hFFFF, 0);
    apply_writes();
    repeat (2) drive_tick(16'sd2, 16'sd2, 16'sd0, 1'b1);
    repeat (2) drive_tick(16'sd3, 16'sd3, 16'sd0, 1'b1);
    stage_reg(REG_LEVEL_WINDOW, 500, 15);
    apply_writes();
    repeat (3) drive_tick(16'sd0, 16'sd0, 16'sd10, 1'b0);
    // interval dropped below the running count: next level tick samples
    stage_reg(REG_SAMPLE_INTERVAL, 2, 10);
    apply_writes();
    drive_tick(16'sd0, 16'sd0, 16'sd10, 1'b0);
    stage_reg(REG_STILL_DELTA, 36000, 16);
    stage_reg(REG_STILL_SAMPLES_NEEDED, 1, 4);
    apply_writes();
    repeat (2) drive_tick(16'sd0, 16'sd0, 16'sd10, 1'b0);

    // Latch at once out of the window, then a spin run at tick limit 1022 and the
    // longest sample interval end on the same tick, no idling
    idle_on = 1'b0;
    stage_reg(REG_SPIN_SPEED_LIMIT, 0, 15);
    stage_reg(REG_SPIN_TICK_LIMIT, 0, 10);
    stage_reg(REG_LEVEL_WINDOW, 18000, 15);
    stage_reg(REG_STILL_DELTA, 36000, 16);
    stage_reg(REG_SAMPLE_INTERVAL, 1023, 10);
    stage_reg(REG_STILL_SAMPLES_NEEDED, 1, 4);
    stage_reg(REG_TILT_LIMIT, 18000, 15);
    apply_writes();
    neg = $urandom_range(1, 0);
    drive_tick(fast_count(0, neg), fast_count(0, neg), 16'sd18000, 1'b1);
    stage_reg(REG_SPIN_TICK_LIMIT, 1022, 10);
    apply_writes();
    repeat (1023)
      drive_tick(fast_count(0, neg), fast_count(0, neg),
                 16'(int'($urandom_range(200, 0)) - 100), 1'b1);

    // Random phases of spin and landing sequences with noise mixed in
    target = items_sent + 950;
    phase  = 0;
    while (items_sent < target) begin
      phase_idle = (phase % 4 != 3);
      idle_on    = phase_idle && (target - items_sent > 250);
      random_settings();
      phase_end = items_sent + 150;
      while (items_sent < phase_end && items_sent < target) begin
        idle_on = phase_idle && (target - items_sent > 250);
        pick = $urandom_range(99, 0);
        if (pick < 45) begin
          spin_episode();
          landing_episode();
        end else if (pick < 60) begin
          spin_episode();
        end else if (pick < 70) begin
          landing_episode();
        end else begin
          repeat ($urandom_range(10, 1)) noise_tick();
        end
        if ($urandom_range(19, 0) == 0) drain_results();
      end
      phase++;
    end

    idle_on = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mfs_pkg.sv
rtl/mfs_if.sv
rtl/mfs_cfg_regs.sv
rtl/mfs_step.sv
rtl/motor_fault_supervisor.sv
verif/mfs_fault_check.sv
verif/tb.sv
